>>> rtl/accc_pkg.sv
package accc_pkg;

    localparam int ChanW   = 8;
    localparam int LinW    = 17;
    localparam int LumaW   = 17;
    localparam int RatioW  = 13;
    localparam int NumW    = 25;
    localparam int DenW    = 17;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 13;

    localparam int DivBitsPerStage = 3;
    localparam int DivStages = (RatioW + DivBitsPerStage - 1) / DivBitsPerStage;

    localparam logic [RatioW-1:0] RatioMax  = 13'd5376;
    localparam logic [DenW-1:0]   LumOffset = 17'd3277;

    localparam logic [15:0] WeightRed   = 16'd13933;
    localparam logic [15:0] WeightGreen = 16'd46871;
    localparam logic [15:0] WeightBlue  = 16'd4732;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic [LinW-1:0]  t_lin;
    typedef t_lin t_lin_table [256];

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_WARN = 2'd1,
        VERDICT_FAIL = 2'd2
    } t_verdict;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BACKDROP_RED   = 3'd0,
        REG_BACKDROP_GREEN = 3'd1,
        REG_BACKDROP_BLUE  = 3'd2,
        REG_PASS_THRESHOLD = 3'd3,
        REG_WARN_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef struct packed {
        t_rgb  fore;
        t_chan fore_alpha;
        t_rgb  surf;
        t_chan surf_alpha;
    } t_pix;

    typedef struct packed {
        t_rgb text;
        t_rgb back;
    } t_col_pair;

    // item moving through the divider stages
    typedef struct packed {
        logic [DenW-1:0]   rem;
        logic [NumW-1:0]   num;
        logic [DenW-1:0]   den;
        logic [RatioW-1:0] quo;
        logic [LumaW-1:0]  y_text;
        logic [LumaW-1:0]  y_back;
    } t_div_item;

    // rounded blend over an opaque bottom, x/255 done as (x + (x>>8) + 1) >> 8
    function automatic t_chan blend8(input t_chan top, input t_chan alpha, input t_chan bot);
        logic [16:0] x;
        logic [16:0] y;
        x = 17'(top * alpha) + 17'(bot * (8'd255 - alpha)) + 17'd127;
        y = x + (x >> 8) + 17'd1;
        return y[15:8];
    endfunction

    function automatic logic [63:0] pow5_q24(input logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int k = 0; k < 4; k++) begin
            p = (p * r) >> 24;
        end
        return p;
    endfunction

    // srgb linearisation, q1.16, evaluated at elaboration only
    function automatic t_lin lin_entry(input int unsigned i);
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lin24;
        logic [63:0] ii;
        ii = 64'(i);
        if (ii * 64'd100000 <= 64'd1001640) begin
            return t_lin'((ii * 64'd6553600 + 64'd164730) / 64'd329460);
        end
        t = (((ii * 64'd1000 + 64'd14025) << 24) + 64'd134512) / 64'd269025;
        v = (t * t + 64'd8388608) >> 24;
        lo = 64'd0;
        hi = 64'd16777216;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow5_q24(mid) <= v) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        lin24 = (v * lo + 64'd8388608) >> 24;
        return t_lin'((lin24 + 64'd128) >> 8);
    endfunction

    function automatic t_lin_table lin_table_build();
        t_lin_table tab;
        for (int unsigned i = 0; i < 256; i++) begin
            tab[i] = lin_entry(i);
        end
        return tab;
    endfunction

    localparam t_lin_table LinTable = lin_table_build();

endpackage

>>> rtl/accc_in_if.sv
interface accc_in_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           fore_red;
    logic [7:0]           fore_green;
    logic [7:0]           fore_blue;
    logic [7:0]           fore_alpha;
    logic [7:0]           surf_red;
    logic [7:0]           surf_green;
    logic [7:0]           surf_blue;
    logic [7:0]           surf_alpha;

    modport source (
        output valid, fore_red, fore_green, fore_blue, fore_alpha,
               surf_red, surf_green, surf_blue, surf_alpha,
        input  ready
    );
    modport sink (
        input  valid, fore_red, fore_green, fore_blue, fore_alpha,
               surf_red, surf_green, surf_blue, surf_alpha,
        output ready
    );
endinterface

>>> rtl/accc_out_if.sv
interface accc_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] contrast_q88;
    logic [1:0]  verdict;
    logic [15:0] text_luminance;
    logic [15:0] back_luminance;

    modport source (
        output valid, contrast_q88, verdict, text_luminance, back_luminance,
        input  ready
    );
    modport sink (
        input  valid, contrast_q88, verdict, text_luminance, back_luminance,
        output ready
    );
endinterface

>>> rtl/accc_blend.sv
module accc_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  accc_pkg::t_pix      i_pix,
    input  accc_pkg::t_rgb      i_backdrop,
    output logic                o_valid,
    input  logic                i_ready,
    output accc_pkg::t_col_pair o_col
);

    logic              r_v1;
    logic              r_v2;
    accc_pkg::t_rgb    r_back1;
    accc_pkg::t_rgb    r_fore1;
    accc_pkg::t_chan   r_fa1;
    accc_pkg::t_col_pair r_col2;
    accc_pkg::t_rgb    n_back1;
    accc_pkg::t_rgb    n_text2;
    logic              en1;
    logic              en2;

    // stage enables, a stage moves when empty or when its successor moves
    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // surface over backdrop
    always_comb begin
        n_back1.red   = accc_pkg::blend8(i_pix.surf.red,   i_pix.surf_alpha, i_backdrop.red);
        n_back1.green = accc_pkg::blend8(i_pix.surf.green, i_pix.surf_alpha, i_backdrop.green);
        n_back1.blue  = accc_pkg::blend8(i_pix.surf.blue,  i_pix.surf_alpha, i_backdrop.blue);
    end

    // foreground over effective background
    always_comb begin
        n_text2.red   = accc_pkg::blend8(r_fore1.red,   r_fa1, r_back1.red);
        n_text2.green = accc_pkg::blend8(r_fore1.green, r_fa1, r_back1.green);
        n_text2.blue  = accc_pkg::blend8(r_fore1.blue,  r_fa1, r_back1.blue);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_back1 <= n_back1;
            r_fore1 <= i_pix.fore;
            r_fa1   <= i_pix.fore_alpha;
        end
        if (en2 && r_v1) begin
            r_col2.back <= r_back1;
            r_col2.text <= n_text2;
        end
    end

    assign o_valid = r_v2;
    assign o_col   = r_col2;

endmodule

>>> rtl/accc_luma.sv
module accc_luma (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  accc_pkg::t_col_pair i_col,
    output logic                o_valid,
    input  logic                i_ready,
    output accc_pkg::t_div_item o_item
);

    logic                r_va;
    logic                r_vb;
    logic                r_vc;
    accc_pkg::t_lin      r_lin [6];
    logic [32:0]         r_prod [6];
    accc_pkg::t_div_item r_item;
    accc_pkg::t_div_item n_item;
    logic [34:0]         sum_text;
    logic [34:0]         sum_back;
    logic [accc_pkg::LumaW-1:0] y_text;
    logic [accc_pkg::LumaW-1:0] y_back;
    logic [accc_pkg::LumaW-1:0] y_hi;
    logic [accc_pkg::DenW-1:0]  hi_off;
    logic [accc_pkg::DenW-1:0]  lo_off;
    logic                ea;
    logic                eb;
    logic                ec;

    assign ec      = !r_vc || i_ready;
    assign eb      = !r_vb || ec;
    assign ea      = !r_va || eb;
    assign o_ready = ea;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ea) r_va <= i_valid;
            if (eb) r_vb <= r_va;
            if (ec) r_vc <= r_vb;
        end
    end

    // table lookups, text then background
    always_ff @(posedge i_clk) begin
        if (ea && i_valid) begin
            r_lin[0] <= accc_pkg::LinTable[i_col.text.red];
            r_lin[1] <= accc_pkg::LinTable[i_col.text.green];
            r_lin[2] <= accc_pkg::LinTable[i_col.text.blue];
            r_lin[3] <= accc_pkg::LinTable[i_col.back.red];
            r_lin[4] <= accc_pkg::LinTable[i_col.back.green];
            r_lin[5] <= accc_pkg::LinTable[i_col.back.blue];
        end
    end

    // rec.709 weights
    always_ff @(posedge i_clk) begin
        if (eb && r_va) begin
            r_prod[0] <= 33'(r_lin[0] * accc_pkg::WeightRed);
            r_prod[1] <= 33'(r_lin[1] * accc_pkg::WeightGreen);
            r_prod[2] <= 33'(r_lin[2] * accc_pkg::WeightBlue);
            r_prod[3] <= 33'(r_lin[3] * accc_pkg::WeightRed);
            r_prod[4] <= 33'(r_lin[4] * accc_pkg::WeightGreen);
            r_prod[5] <= 33'(r_lin[5] * accc_pkg::WeightBlue);
        end
    end

    // luminance sums, ordering and divider operands
    always_comb begin
        sum_text = 35'(r_prod[0]) + 35'(r_prod[1]) + 35'(r_prod[2]) + 35'd32768;
        sum_back = 35'(r_prod[3]) + 35'(r_prod[4]) + 35'(r_prod[5]) + 35'd32768;
        y_text   = sum_text[32:16];
        y_back   = sum_back[32:16];
        if (y_text > y_back) begin
            y_hi   = y_text;
            lo_off = y_back + accc_pkg::LumOffset;
        end else begin
            y_hi   = y_back;
            lo_off = y_text + accc_pkg::LumOffset;
        end
        hi_off        = y_hi + accc_pkg::LumOffset;
        n_item.num    = {hi_off, 8'd0} + accc_pkg::NumW'(lo_off >> 1);
        n_item.den    = lo_off;
        n_item.rem    = accc_pkg::DenW'(n_item.num[accc_pkg::NumW-1:accc_pkg::RatioW]);
        n_item.quo    = '0;
        n_item.y_text = y_text;
        n_item.y_back = y_back;
    end

    always_ff @(posedge i_clk) begin
        if (ec && r_vb) r_item <= n_item;
    end

    assign o_valid = r_vc;
    assign o_item  = r_item;

endmodule

>>> rtl/accc_div.sv
module accc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  accc_pkg::t_div_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output accc_pkg::t_div_item o_item
);

    localparam int NS = accc_pkg::DivStages;

    logic                r_v    [NS];
    accc_pkg::t_div_item r_st   [NS];
    accc_pkg::t_div_item n_st   [NS];
    logic                en     [NS];
    logic                vin    [NS];

    // a few restoring steps per stage, quotient msb first
    function automatic accc_pkg::t_div_item div_step(input accc_pkg::t_div_item x, input int s);
        accc_pkg::t_div_item y;
        logic [accc_pkg::DenW:0] trial;
        int j;
        y = x;
        for (int k = 0; k < accc_pkg::DivBitsPerStage; k++) begin
            j = accc_pkg::RatioW - 1 - accc_pkg::DivBitsPerStage * s - k;
            if (j >= 0) begin
                trial = {y.rem, y.num[j]};
                if (trial >= {1'b0, y.den}) begin
                    trial    = trial - {1'b0, y.den};
                    y.quo[j] = 1'b1;
                end
                y.rem = trial[accc_pkg::DenW-1:0];
            end
        end
        return y;
    endfunction

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == NS - 1) begin : g_last
            assign en[s] = !r_v[s] || i_ready;
        end else begin : g_mid
            assign en[s] = !r_v[s] || en[s+1];
        end
        if (s == 0) begin : g_first
            assign vin[s]  = i_valid;
            assign n_st[s] = div_step(i_item, s);
        end else begin : g_next
            assign vin[s]  = r_v[s-1];
            assign n_st[s] = div_step(r_st[s-1], s);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s] && vin[s]) r_st[s] <= n_st[s];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_item  = r_st[NS-1];

endmodule

>>> rtl/alpha_composite_contrast_check.sv
// Contrast checker for a pair of rgba colours: the surface is blended over the
// opaque backdrop held in the configuration registers, the foreground over that,
// and the wcag contrast ratio of the two results is reported in q5.8 (1.0 to
// 21.0, saturated) with a pass/warn/fail verdict and both luminances in q0.16.
// A new pair is taken every clock cycle while the output is not held off;
// each result passes through two blend stages, three luminance stages, five
// divider stages of up to three quotient bits each and one output register,
// and stalls in place while the output is held off. Write configuration only
// while no pair is in flight.
module alpha_composite_contrast_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    accc_in_if.sink                           i_in,
    accc_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [accc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [accc_pkg::CfgW-1:0]         i_cfg_data
);

    accc_pkg::t_rgb             r_backdrop;
    logic [accc_pkg::RatioW-1:0] r_pass_thr;
    logic [accc_pkg::RatioW-1:0] r_warn_thr;

    accc_pkg::t_pix             pix;
    logic                       bl_valid;
    logic                       bl_ready;
    accc_pkg::t_col_pair        bl_col;
    logic                       lu_valid;
    logic                       lu_ready;
    accc_pkg::t_div_item        lu_item;
    logic                       dv_valid;
    logic                       dv_ready;
    accc_pkg::t_div_item        dv_item;

    logic                       r_ov;
    logic [accc_pkg::RatioW-1:0] r_ratio;
    accc_pkg::t_verdict         r_verdict;
    logic [15:0]                r_y_text;
    logic [15:0]                r_y_back;
    logic [accc_pkg::RatioW-1:0] n_ratio;
    accc_pkg::t_verdict         n_verdict;
    logic                       out_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backdrop.red   <= 8'd128;
            r_backdrop.green <= 8'd128;
            r_backdrop.blue  <= 8'd128;
            r_pass_thr       <= 13'd1152;
            r_warn_thr       <= 13'd768;
        end else if (i_cfg_we) begin
            unique case (accc_pkg::t_cfg_idx'(i_cfg_idx))
                accc_pkg::REG_BACKDROP_RED:   r_backdrop.red   <= i_cfg_data[7:0];
                accc_pkg::REG_BACKDROP_GREEN: r_backdrop.green <= i_cfg_data[7:0];
                accc_pkg::REG_BACKDROP_BLUE:  r_backdrop.blue  <= i_cfg_data[7:0];
                accc_pkg::REG_PASS_THRESHOLD: r_pass_thr       <= i_cfg_data;
                accc_pkg::REG_WARN_THRESHOLD: r_warn_thr       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input payload
    always_comb begin
        pix.fore.red   = i_in.fore_red;
        pix.fore.green = i_in.fore_green;
        pix.fore.blue  = i_in.fore_blue;
        pix.fore_alpha = i_in.fore_alpha;
        pix.surf.red   = i_in.surf_red;
        pix.surf.green = i_in.surf_green;
        pix.surf.blue  = i_in.surf_blue;
        pix.surf_alpha = i_in.surf_alpha;
    end

    accc_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_pix      (pix),
        .i_backdrop (r_backdrop),
        .o_valid    (bl_valid),
        .i_ready    (bl_ready),
        .o_col      (bl_col)
    );

    accc_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bl_valid),
        .o_ready (bl_ready),
        .i_col   (bl_col),
        .o_valid (lu_valid),
        .i_ready (lu_ready),
        .o_item  (lu_item)
    );

    accc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lu_valid),
        .o_ready (lu_ready),
        .i_item  (lu_item),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_item  (dv_item)
    );

    // saturation and verdict
    always_comb begin
        n_ratio = (dv_item.quo > accc_pkg::RatioMax) ? accc_pkg::RatioMax : dv_item.quo;
        if (n_ratio >= r_pass_thr) begin
            n_verdict = accc_pkg::VERDICT_PASS;
        end else if (n_ratio >= r_warn_thr) begin
            n_verdict = accc_pkg::VERDICT_WARN;
        end else begin
            n_verdict = accc_pkg::VERDICT_FAIL;
        end
    end

    // output register
    assign out_en   = !r_ov || o_out.ready;
    assign dv_ready = out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_en) begin
            r_ov <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && dv_valid) begin
            r_ratio   <= n_ratio;
            r_verdict <= n_verdict;
            r_y_text  <= dv_item.y_text[16] ? 16'hFFFF : dv_item.y_text[15:0];
            r_y_back  <= dv_item.y_back[16] ? 16'hFFFF : dv_item.y_back[15:0];
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.contrast_q88   = r_ratio;
    assign o_out.verdict        = r_verdict;
    assign o_out.text_luminance = r_y_text;
    assign o_out.back_luminance = r_y_back;

    // ratio of a delivered transfer stays within 1.0 .. 21.0
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.contrast_q88 >= 13'd256 && o_out.contrast_q88 <= 13'd5376))
        else $error("contrast ratio out of range");

    // pass only at or above the pass threshold
    a_pass_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.verdict == accc_pkg::VERDICT_PASS)
            |-> o_out.contrast_q88 >= r_pass_thr)
        else $error("pass verdict below threshold");

    // fail only below both thresholds
    a_fail_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.verdict == accc_pkg::VERDICT_FAIL)
            |-> (o_out.contrast_q88 < r_pass_thr && o_out.contrast_q88 < r_warn_thr))
        else $error("fail verdict at or above a threshold");

    // nothing is presented in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");

endmodule
